>>> rtl/swrm_pkg.sv
// swrm_pkg: shared types and constants for the sliding window rate meter
// beat structs, command codes, sequencer states and default sizes
// no dependencies
package swrm_pkg;

    // default ring size and reset window length
    localparam int            DEFAULT_SAMPLE_DEPTH = 64;
    localparam logic [15:0]   WINDOW_MS_RESET      = 16'd1000;

    // field widths fixed by the interface
    localparam int            DATA_W     = 32;
    localparam int            WINDOW_W   = 16;
    localparam int            ENTRIES_W  = 7;
    localparam int            STEP_CNT_W = 5;
    localparam logic [4:0]    DIV_LAST_STEP = 5'd31;

    // command codes
    localparam logic [1:0]    CMD_ADD   = 2'd0;
    localparam logic [1:0]    CMD_START = 2'd1;
    localparam logic [1:0]    CMD_STOP  = 2'd2;

    // input beat
    typedef struct packed {
        logic [1:0]        command;
        logic [DATA_W-1:0] added_bytes;
        logic [DATA_W-1:0] now_ms;
    } item_t;

    // output beat
    typedef struct packed {
        logic [DATA_W-1:0]    window_speed;
        logic [DATA_W-1:0]    average_speed;
        logic                 is_running;
        logic [ENTRIES_W-1:0] window_entries;
    } result_t;

    // one stored ring sample
    typedef struct packed {
        logic [DATA_W-1:0] time_ms;
        logic [DATA_W-1:0] total;
    } sample_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXP_RD,
        ST_EXP_CHK,
        ST_APPLY,
        ST_WIN_START,
        ST_WIN_CHK,
        ST_RD_OLD,
        ST_RD_NEW,
        ST_DIV_WIN,
        ST_MEAN_SET,
        ST_DIV_MEAN,
        ST_DONE
    } state_t;

    // which expiry walk is running
    typedef enum logic {
        PASS_PRE,
        PASS_WIN
    } pass_t;

endpackage

>>> rtl/swrm_ram.sv
// swrm_ram: generic single write, single read ram with registered read data
// depends on nothing; used for the sample ring of the rate meter
module swrm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wen,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            ram_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= ram_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/sliding_window_rate_meter.sv
// an item is accepted in idle; an add first runs an expiry walk (read, then check, per sample
// examined), then the command is applied and the window set up; while running a second walk and
// the window check follow, then two endpoint reads with two or more samples and a window speed
// division when the span is nonzero; then the mean setup, an average division when elapsed is
// nonzero, and the output load; one item is in work at a time, the next is taken once the result
// sits in the output register, even while it waits; async active low reset clears control state only
module sliding_window_rate_meter
    import swrm_pkg::*;
#(
    parameter int SAMPLE_DEPTH = DEFAULT_SAMPLE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wen,
    input  logic [WINDOW_W-1:0] cfg_wdata,
    input  logic                item_valid,
    output logic                item_ready,
    input  item_t               item,
    output logic                result_valid,
    input  logic                result_ready,
    output result_t             result
);

    localparam int IDX_W = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(SAMPLE_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SAMPLE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(SAMPLE_DEPTH);
    localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(SAMPLE_DEPTH);
    localparam logic [CNT_W-1:0] TWO_CNT = CNT_W'(2);

    // control registers
    state_t              state_reg,  state_next;
    pass_t               pass_reg,   pass_next;
    logic [WINDOW_W-1:0] window_reg, window_next;
    logic                running_reg, running_next;
    logic [DATA_W-1:0]   total_reg,  total_next;
    logic [DATA_W-1:0]   start_reg,  start_next;
    logic [DATA_W-1:0]   end_reg,    end_next;
    logic [IDX_W-1:0]    head_reg,   head_next;
    logic [CNT_W-1:0]    count_reg,  count_next;
    logic                result_valid_reg, result_valid_next;

    // payload registers
    logic [1:0]          cmd_reg,    cmd_next;
    logic [DATA_W-1:0]   bytes_reg,  bytes_next;
    logic [DATA_W-1:0]   now_reg,    now_next;
    sample_t             old_reg,    old_next;
    logic [DATA_W-1:0]   rem_reg,    rem_next;
    logic [DATA_W-1:0]   quo_reg,    quo_next;
    logic [DATA_W-1:0]   div_reg,    div_next;
    logic [STEP_CNT_W-1:0] step_reg, step_next;
    logic [DATA_W-1:0]   win_reg,    win_next;
    result_t             result_reg, result_next;

    // ring ram port signals
    logic                ram_wen;
    logic [IDX_W-1:0]    ram_waddr;
    sample_t             ram_wdata;
    logic [IDX_W-1:0]    ram_raddr;
    sample_t             ram_rdata;

    // helpers
    logic [IDX_W-1:0]    head_inc;
    logic [SUM_W-1:0]    tail_sum;
    logic [IDX_W-1:0]    tail_idx;
    logic [SUM_W-1:0]    newest_sum;
    logic [IDX_W-1:0]    newest_idx;
    logic [DATA_W-1:0]   age;
    logic                expired;
    logic [DATA_W:0]     trial;
    logic [DATA_W:0]     trial_diff;
    logic                trial_ge;
    logic [DATA_W-1:0]   rem_step;
    logic [DATA_W-1:0]   quo_step;
    logic [DATA_W-1:0]   span;
    logic [DATA_W-1:0]   bytes_span;
    logic [DATA_W-1:0]   elapsed;
    logic [DATA_W-1:0]   sum_total;

    swrm_ram #(
        .WIDTH ($bits(sample_t)),
        .DEPTH (SAMPLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .wen   (ram_wen),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ring index arithmetic
    always_comb
    begin
        head_inc   = (head_reg == LAST_IDX) ? '0 : head_reg + IDX_W'(1);
        tail_sum   = SUM_W'(head_reg) + SUM_W'(count_reg);
        if (tail_sum >= DEPTH_SUM)
        begin
            tail_sum = tail_sum - DEPTH_SUM;
        end
        tail_idx   = tail_sum[IDX_W-1:0];
        newest_sum = SUM_W'(head_reg) + SUM_W'(count_reg) - SUM_W'(1);
        if (newest_sum >= DEPTH_SUM)
        begin
            newest_sum = newest_sum - DEPTH_SUM;
        end
        newest_idx = newest_sum[IDX_W-1:0];
    end

    // shared restoring divider step, one quotient bit a cycle
    always_comb
    begin
        trial      = {rem_reg, quo_reg[DATA_W-1]};
        trial_diff = trial - {1'b0, div_reg};
        trial_ge   = ~trial_diff[DATA_W];
        rem_step   = trial_ge ? trial_diff[DATA_W-1:0] : trial[DATA_W-1:0];
        quo_step   = {quo_reg[DATA_W-2:0], trial_ge};
    end

    // datapath terms
    assign age        = now_reg - ram_rdata.time_ms;
    assign expired    = age > DATA_W'(window_reg);
    assign span       = ram_rdata.time_ms - old_reg.time_ms;
    assign bytes_span = ram_rdata.total - old_reg.total;
    assign elapsed    = (running_reg ? now_reg : end_reg) - start_reg;
    assign sum_total  = total_reg + bytes_reg;
    assign ram_raddr  = (state_reg == ST_RD_OLD) ? newest_idx : head_reg;

    // sequencer: next state and datapath control
    always_comb
    begin
        state_next        = state_reg;
        pass_next         = pass_reg;
        window_next       = window_reg;
        running_next      = running_reg;
        total_next        = total_reg;
        start_next        = start_reg;
        end_next          = end_reg;
        head_next         = head_reg;
        count_next        = count_reg;
        result_valid_next = result_valid_reg & ~result_ready;
        cmd_next          = cmd_reg;
        bytes_next        = bytes_reg;
        now_next          = now_reg;
        old_next          = old_reg;
        rem_next          = rem_reg;
        quo_next          = quo_reg;
        div_next          = div_reg;
        step_next         = step_reg;
        win_next          = win_reg;
        result_next       = result_reg;
        ram_wen           = 1'b0;
        ram_waddr         = tail_idx;
        ram_wdata.time_ms = now_reg;
        ram_wdata.total   = sum_total;

        if (cfg_wen)
        begin
            window_next = cfg_wdata;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd_next   = item.command;
                    bytes_next = item.added_bytes;
                    now_next   = item.now_ms;
                    pass_next  = PASS_PRE;
                    state_next = (item.command == CMD_ADD) ? ST_EXP_RD : ST_APPLY;
                end
            end
            ST_EXP_RD:
            begin
                if (count_reg == '0)
                begin
                    state_next = (pass_reg == PASS_PRE) ? ST_APPLY : ST_WIN_CHK;
                end
                else
                begin
                    state_next = ST_EXP_CHK;
                end
            end
            ST_EXP_CHK:
            begin
                if (expired)
                begin
                    head_next  = head_inc;
                    count_next = count_reg - CNT_W'(1);
                    state_next = ST_EXP_RD;
                end
                else
                begin
                    state_next = (pass_reg == PASS_PRE) ? ST_APPLY : ST_WIN_CHK;
                end
            end
            ST_APPLY:
            begin
                case (cmd_reg)
                    CMD_ADD:
                    begin
                        total_next = sum_total;
                        ram_wen    = 1'b1;
                        if (count_reg == FULL_CNT)
                        begin
                            ram_waddr = head_reg;
                            head_next = head_inc;
                        end
                        else
                        begin
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    CMD_START:
                    begin
                        running_next = 1'b1;
                        total_next   = '0;
                        head_next    = '0;
                        count_next   = '0;
                        start_next   = now_reg;
                    end
                    CMD_STOP:
                    begin
                        end_next     = now_reg;
                        running_next = 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
                state_next = ST_WIN_START;
            end
            ST_WIN_START:
            begin
                if (running_reg)
                begin
                    pass_next  = PASS_WIN;
                    state_next = ST_EXP_RD;
                end
                else
                begin
                    win_next   = '0;
                    state_next = ST_MEAN_SET;
                end
            end
            ST_WIN_CHK:
            begin
                if (count_reg < TWO_CNT)
                begin
                    win_next   = '0;
                    state_next = ST_MEAN_SET;
                end
                else
                begin
                    state_next = ST_RD_OLD;
                end
            end
            ST_RD_OLD:
            begin
                old_next   = ram_rdata;
                state_next = ST_RD_NEW;
            end
            ST_RD_NEW:
            begin
                if (span == '0)
                begin
                    win_next   = '0;
                    state_next = ST_MEAN_SET;
                end
                else
                begin
                    rem_next   = '0;
                    quo_next   = bytes_span;
                    div_next   = span;
                    step_next  = '0;
                    state_next = ST_DIV_WIN;
                end
            end
            ST_DIV_WIN:
            begin
                rem_next  = rem_step;
                quo_next  = quo_step;
                step_next = step_reg + STEP_CNT_W'(1);
                if (step_reg == DIV_LAST_STEP)
                begin
                    win_next   = quo_step;
                    state_next = ST_MEAN_SET;
                end
            end
            ST_MEAN_SET:
            begin
                if (elapsed == '0)
                begin
                    quo_next   = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    rem_next   = '0;
                    quo_next   = total_reg;
                    div_next   = elapsed;
                    step_next  = '0;
                    state_next = ST_DIV_MEAN;
                end
            end
            ST_DIV_MEAN:
            begin
                rem_next  = rem_step;
                quo_next  = quo_step;
                step_next = step_reg + STEP_CNT_W'(1);
                if (step_reg == DIV_LAST_STEP)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // load the output register once the previous beat has left
                if (!result_valid_reg || result_ready)
                begin
                    result_next.window_speed   = win_reg;
                    result_next.average_speed  = quo_reg;
                    result_next.is_running     = running_reg;
                    result_next.window_entries = ENTRIES_W'(count_reg);
                    result_valid_next          = 1'b1;
                    state_next                 = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            pass_reg         <= PASS_PRE;
            window_reg       <= WINDOW_MS_RESET;
            running_reg      <= 1'b0;
            total_reg        <= '0;
            start_reg        <= '0;
            end_reg          <= '0;
            head_reg         <= '0;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            pass_reg         <= pass_next;
            window_reg       <= window_next;
            running_reg      <= running_next;
            total_reg        <= total_next;
            start_reg        <= start_next;
            end_reg          <= end_next;
            head_reg         <= head_next;
            count_reg        <= count_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // payload and divider registers
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        bytes_reg  <= bytes_next;
        now_reg    <= now_next;
        old_reg    <= old_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        div_reg    <= div_next;
        step_reg   <= step_next;
        win_reg    <= win_next;
        result_reg <= result_next;
    end

    assign item_ready   = (state_reg == ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

>>> rtl/swrm_checker.sv
// swrm_checker: port level assertions for the sliding window rate meter
// depends on swrm_pkg; bound to sliding_window_rate_meter below
module swrm_checker
    import swrm_pkg::*;
#(
    parameter int SAMPLE_DEPTH = DEFAULT_SAMPLE_DEPTH
) (
    input logic    clk,
    input logic    rst_n,
    input logic    item_valid,
    input logic    item_ready,
    input logic    result_valid,
    input logic    result_ready,
    input result_t result
);

    localparam bit ENTRIES_EXACT = (SAMPLE_DEPTH < (1 << ENTRIES_W));
    localparam logic [ENTRIES_W-1:0] MAX_ENTRIES = ENTRIES_W'(SAMPLE_DEPTH);

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result beat changed while stalled");

    // one item at a time: ready drops after every accepted beat
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("item taken while previous one still in work");

    // no window speed while stopped
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.is_running |-> result.window_speed == '0)
        else $error("window speed reported while not running");

    // ring never holds more than its depth
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && ENTRIES_EXACT |-> result.window_entries <= MAX_ENTRIES)
        else $error("window entry count exceeds ring depth");

    // a window of fewer than two samples has no speed
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && ENTRIES_EXACT && result.window_entries < ENTRIES_W'(2)
            |-> result.window_speed == '0)
        else $error("window speed from fewer than two samples");

endmodule

bind sliding_window_rate_meter swrm_checker #(
    .SAMPLE_DEPTH (SAMPLE_DEPTH)
) u_swrm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// tb_top: self-checking bench for sliding_window_rate_meter, one report beat per item beat
// directed table then random traffic, checked against fixed reports or an in-bench rate meter predictor
// depends on swrm_pkg and the sliding_window_rate_meter rtl
module tb_top;
    import swrm_pkg::*;

    // command value the block has no use for
    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam int         RING_DEPTH  = DEFAULT_SAMPLE_DEPTH;
    localparam int         CYCLE_LIMIT = 2_000_000;
    localparam int         LONG_HOLD   = 1500;
    localparam int         HOLD_AT     = 560;
    localparam int         DRAIN_PAUSE = 8;
    localparam int         TAIL_CYCLES = 400;

    typedef enum logic {
        ROW_BEAT,
        ROW_WINDOW
    } row_kind_t;

    // one line of the directed table
    typedef struct {
        row_kind_t           kind;
        item_t               beat;
        logic                fixed;
        result_t             want;
        logic [WINDOW_W-1:0] win;
    } plan_row_t;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                cfg_wen      = 1'b0;
    logic [WINDOW_W-1:0] cfg_wdata    = '0;
    logic                item_valid   = 1'b0;
    logic                item_ready;
    item_t               item         = '0;
    logic                result_valid;
    logic                result_ready = 1'b0;
    result_t             result;

    // rate meter predictor state
    logic [WINDOW_W-1:0] meter_window = WINDOW_MS_RESET;
    logic                meter_running = 1'b0;
    logic [DATA_W-1:0]   meter_total   = '0;
    logic [DATA_W-1:0]   meter_start   = '0;
    logic [DATA_W-1:0]   meter_end     = '0;
    logic [DATA_W-1:0]   ring_stamp [RING_DEPTH];
    logic [DATA_W-1:0]   ring_sum   [RING_DEPTH];
    int                  ring_oldest = 0;
    int                  ring_fill   = 0;

    result_t             awaited_reports[$];
    logic [DATA_W-1:0]   traffic_clock;
    int                  tx_idle_pct  = 0;
    int                  rx_idle_pct  = 0;
    int                  beats_sent   = 0;
    int                  reports_seen = 0;
    int                  mismatches   = 0;
    int                  hold_left    = 0;
    bit                  hold_done    = 1'b0;
    int                  cycle_count  = 0;

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    sliding_window_rate_meter u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wen      (cfg_wen),
        .cfg_wdata    (cfg_wdata),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // drop samples older than the window at time now
    function automatic void drop_stale(input logic [DATA_W-1:0] now);
        logic [DATA_W-1:0] age;
        while (ring_fill > 0)
        begin
            age = now - ring_stamp[ring_oldest];
            if (age <= {16'd0, meter_window})
                break;
            ring_oldest = (ring_oldest + 1) % RING_DEPTH;
            ring_fill--;
        end
    endfunction

    // apply one item beat and compute the report it produces
    function automatic result_t meter_step(input item_t it);
        result_t           rep;
        int                slot;
        int                newest;
        logic [DATA_W-1:0] span;
        logic [DATA_W-1:0] finish_ms;
        logic [DATA_W-1:0] elapsed;
        case (it.command)
            CMD_ADD:
            begin
                drop_stale(it.now_ms);
                meter_total = meter_total + it.added_bytes;
                if (ring_fill >= RING_DEPTH)
                begin
                    slot        = ring_oldest;
                    ring_oldest = (ring_oldest + 1) % RING_DEPTH;
                end
                else
                begin
                    slot = (ring_oldest + ring_fill) % RING_DEPTH;
                    ring_fill++;
                end
                ring_stamp[slot] = it.now_ms;
                ring_sum[slot]   = meter_total;
            end
            CMD_START:
            begin
                meter_running = 1'b1;
                meter_total   = '0;
                ring_oldest   = 0;
                ring_fill     = 0;
                meter_start   = it.now_ms;
            end
            CMD_STOP:
            begin
                meter_end     = it.now_ms;
                meter_running = 1'b0;
            end
            default: ;
        endcase

        // window speed, expiry only while running
        rep.window_speed = '0;
        if (meter_running)
        begin
            drop_stale(it.now_ms);
            if (ring_fill >= 2)
            begin
                newest = (ring_oldest + ring_fill - 1) % RING_DEPTH;
                span   = ring_stamp[newest] - ring_stamp[ring_oldest];
                if (span != 0)
                    rep.window_speed = (ring_sum[newest] - ring_sum[ring_oldest]) / span;
            end
        end

        // average since start, zero elapsed gives zero
        finish_ms         = meter_running ? it.now_ms : meter_end;
        elapsed           = finish_ms - meter_start;
        rep.average_speed = (elapsed == 0) ? '0 : meter_total / elapsed;
        rep.is_running     = meter_running;
        rep.window_entries = ENTRIES_W'(ring_fill);
        return rep;
    endfunction

    function automatic plan_row_t beat_row(input logic [1:0] cmd, input logic [DATA_W-1:0] bytes,
                                           input logic [DATA_W-1:0] now);
        plan_row_t row;
        row.kind  = ROW_BEAT;
        row.beat  = '{command: cmd, added_bytes: bytes, now_ms: now};
        row.fixed = 1'b0;
        row.want  = '0;
        row.win   = '0;
        return row;
    endfunction

    // rows whose report is plainly zero speed with a known flag and fill
    function automatic plan_row_t checked_row(input logic [1:0] cmd, input logic [DATA_W-1:0] bytes,
                                              input logic [DATA_W-1:0] now, input logic run,
                                              input int entries);
        plan_row_t row;
        row       = beat_row(cmd, bytes, now);
        row.fixed = 1'b1;
        row.want  = '{window_speed: '0, average_speed: '0, is_running: run,
                      window_entries: ENTRIES_W'(entries)};
        return row;
    endfunction

    function automatic plan_row_t window_row(input logic [WINDOW_W-1:0] win);
        plan_row_t row;
        row      = beat_row(CMD_ADD, '0, '0);
        row.kind = ROW_WINDOW;
        row.win  = win;
        return row;
    endfunction

    // offer one item beat, predict its report once accepted
    task automatic push_beat(input item_t it, input logic fixed, input result_t want);
        result_t predicted;
        if ($urandom_range(0, 99) < tx_idle_pct)
        begin
            item_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < tx_idle_pct);
        end
        item       <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        predicted = meter_step(it);
        awaited_reports.push_back(fixed ? want : predicted);
        beats_sent++;
    endtask

    // stop offering and wait for every awaited report
    task automatic wait_idle(input int pause);
        item_valid <= 1'b0;
        while (awaited_reports.size() != 0)
            @(posedge clk);
        repeat (pause) @(posedge clk);
    endtask

    task automatic set_window(input logic [WINDOW_W-1:0] win);
        wait_idle(DRAIN_PAUSE);
        cfg_wdata <= win;
        cfg_wen   <= 1'b1;
        @(posedge clk);
        cfg_wen      <= 1'b0;
        meter_window  = win;
    endtask

    // measurement runs with random content, some controls and stray timestamps
    task automatic run_traffic(input int beats, input int step_max, input int ctl_pct);
        item_t it;
        int    pick;
        for (int n = 0; n < beats; n++)
        begin
            pick           = $urandom_range(0, 99);
            it.added_bytes = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 5000);
            if (pick < ctl_pct)
                it.command = CMD_START;
            else if (pick < 2 * ctl_pct)
                it.command = CMD_STOP;
            else if (pick < 2 * ctl_pct + 2)
                it.command = CMD_UNUSED;
            else
                it.command = CMD_ADD;
            if (pick >= 94)
                it.now_ms = $urandom;
            else
            begin
                traffic_clock = traffic_clock + $urandom_range(0, step_max);
                it.now_ms     = traffic_clock;
            end
            push_beat(it, 1'b0, '0);
        end
    endtask

    // report checker and result_ready driver
    always @(posedge clk)
    begin : report_side
        result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            reports_seen++;
            if (awaited_reports.size() == 0)
            begin
                $display("%0t unexpected report beat: expected none, got %p", $time, result);
                mismatches++;
            end
            else
            begin
                want = awaited_reports.pop_front();
                if (result.window_speed !== want.window_speed)
                begin
                    $display("%0t window_speed: expected %0d, got %0d",
                             $time, want.window_speed, result.window_speed);
                    mismatches++;
                end
                if (result.average_speed !== want.average_speed)
                begin
                    $display("%0t average_speed: expected %0d, got %0d",
                             $time, want.average_speed, result.average_speed);
                    mismatches++;
                end
                if (result.is_running !== want.is_running)
                begin
                    $display("%0t is_running: expected %0d, got %0d",
                             $time, want.is_running, result.is_running);
                    mismatches++;
                end
                if (result.window_entries !== want.window_entries)
                begin
                    $display("%0t window_entries: expected %0d, got %0d",
                             $time, want.window_entries, result.window_entries);
                    mismatches++;
                end
            end
        end

        // one long hold-off so the block backs up into its input
        if (hold_left > 0)
        begin
            hold_left--;
            result_ready <= 1'b0;
        end
        else if (!hold_done && reports_seen == HOLD_AT)
        begin
            hold_done     = 1'b1;
            hold_left     = LONG_HOLD;
            result_ready <= 1'b0;
        end
        else
            result_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d reports still awaited",
                     cycle_count, awaited_reports.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        plan_row_t plan[$];
        int        leftover;
        logic [WINDOW_W-1:0] last_window;

        traffic_clock = $urandom;
        tx_idle_pct   = 7;
        rx_idle_pct   = 84;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // after reset, unused command, stop without start
        plan.push_back(checked_row(CMD_ADD, 32'd0, 32'd0, 1'b0, 1));
        plan.push_back(checked_row(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1));
        plan.push_back(checked_row(CMD_STOP, 32'd0, 32'd100, 1'b0, 1));
        // start near the wrap, restart, zero elapsed and zero span
        plan.push_back(checked_row(CMD_START, 32'd0, 32'hFFFF_FF00, 1'b1, 0));
        plan.push_back(checked_row(CMD_START, 32'd0, 32'hFFFF_FF00, 1'b1, 0));
        plan.push_back(checked_row(CMD_ADD, 32'd1000, 32'hFFFF_FF00, 1'b1, 1));
        plan.push_back(checked_row(CMD_ADD, 32'd500, 32'hFFFF_FF00, 1'b1, 2));
        // time wrap, total wrap, expiry, unused while running
        plan.push_back(beat_row(CMD_ADD, 32'd3000, 32'h0000_0010));
        plan.push_back(beat_row(CMD_ADD, 32'hFFFF_FFFF, 32'h0000_0020));
        plan.push_back(beat_row(CMD_ADD, 32'd0, 32'h0000_0500));
        plan.push_back(beat_row(CMD_UNUSED, 32'd0, 32'h0000_0900));
        // stop, then add while stopped
        plan.push_back(beat_row(CMD_STOP, 32'd0, 32'h0000_0A00));
        plan.push_back(beat_row(CMD_ADD, 32'd77, 32'h0000_0B00));
        // zero window keeps only samples of age zero
        plan.push_back(window_row(16'd0));
        plan.push_back(checked_row(CMD_START, 32'd0, 32'h0000_1000, 1'b1, 0));
        plan.push_back(beat_row(CMD_ADD, 32'd10, 32'h0000_1000));
        plan.push_back(beat_row(CMD_ADD, 32'd20, 32'h0000_1000));
        plan.push_back(beat_row(CMD_ADD, 32'd30, 32'h0000_1001));
        // widest window, age exactly at the limit then one past it
        plan.push_back(window_row(16'hFFFF));
        plan.push_back(checked_row(CMD_START, 32'd0, 32'd0, 1'b1, 0));
        plan.push_back(beat_row(CMD_ADD, 32'hFFFF_FFFF, 32'd1));
        plan.push_back(beat_row(CMD_ADD, 32'hFFFF_FFFF, 32'd65536));
        plan.push_back(beat_row(CMD_ADD, 32'd0, 32'd65537));

        foreach (plan[k])
        begin
            if (plan[k].kind == ROW_WINDOW)
                set_window(plan[k].win);
            else
                push_beat(plan[k].beat, plan[k].fixed, plan[k].want);
        end

        // shortest window, sender mostly busy, receiver mostly stalled
        set_window(16'd1);
        run_traffic(240, 2, 4);

        // widest window with long runs so the ring wraps, roles swapped
        set_window(16'hFFFF);
        tx_idle_pct = 84;
        rx_idle_pct = 7;
        run_traffic(240, 600, 1);

        // mid window, no idling, long receiver hold-off lands here
        last_window = WINDOW_W'($urandom_range(20, 400));
        set_window(last_window);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_traffic(220, 30, 3);

        wait_idle(TAIL_CYCLES);
        leftover = awaited_reports.size();
        if (leftover != 0)
            $display("%0t %0d reports awaited but never seen", $time, leftover);

        $display("sent %0d item beats, checked %0d report beats, %0d mismatches",
                 beats_sent, reports_seen, mismatches);
        $display("windows 1000, 0, 65535, 1, 65535 and %0d ms under three idle patterns",
                 last_window);
        if (mismatches == 0 && leftover == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
